FILE: rtl/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared constants, types and helpers for the LIFO stack with search.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int WORD_WIDTH  = 32;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam int OP_W     = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 5;

   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic push;
      logic pop;
      logic load;
      logic scan;
   } cell_ctrl_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] data_out;
      logic                     found;
      logic [POS_W-1:0]         position;
      logic [POS_W-1:0]         entry_count;
      logic                     last;
   } rsp_type;

   function automatic logic [WORD_WIDTH-1:0] to_word(input logic signed [DATA_W-1:0] v);
      logic signed [63:0] wide;
      wide = 64'(v);
      return wide[WORD_WIDTH-1:0];
   endfunction

   function automatic logic signed [DATA_W-1:0] from_word(input logic [WORD_WIDTH-1:0] w);
      logic signed [63:0] wide;
      wide = 64'(signed'(w));
      return wide[DATA_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/lss_cell.sv
// ----------------------------------------------------------------------------
// lss_cell
// One stack entry: shifts down on push, up on pop, and holds a match flag
// that is loaded on search and passed towards the top during the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_cell
   import lss_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cell_ctrl_type         ctrl,
   input  wire logic                  occupied,
   input  wire logic [WORD_WIDTH-1:0] key,
   input  wire logic [WORD_WIDTH-1:0] above_word,
   input  wire logic [WORD_WIDTH-1:0] below_word,
   input  wire logic                  below_match,
   output logic      [WORD_WIDTH-1:0] word_out,
   output logic                       match_out
);

   logic [WORD_WIDTH-1:0] word_ff, word_in;
   logic                  match_ff, match_in;

   always_comb begin
      word_in  = word_ff;
      match_in = match_ff;
      if (ctrl.push) begin
         word_in = above_word;
      end else if (ctrl.pop) begin
         word_in = below_word;
      end
      if (ctrl.load) begin
         match_in = occupied && (word_ff == key);
      end else if (ctrl.scan) begin
         match_in = below_match;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      if (reset) begin
         match_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
      end
   end

   assign word_out  = word_ff;
   assign match_out = match_ff;

endmodule

`default_nettype wire

FILE: rtl/lifo_stack_with_search.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search
// Bounded LIFO stack of signed words held in a chain of shift cells, with a
// linear search that reports every matching position from the top down.
// ----------------------------------------------------------------------------
// Push and pop: result registered in the cycle after the request beat.
// Search: match flags load first, then the flag chain scans one entry per cycle
// towards the top, holding while a match at the top waits on a stalled output.
// One request in flight at a time; the next beat is taken once back in idle.
// Reset clears the entry count, the scan state and the result valid; the
// entries themselves are undefined until pushed.
`default_nettype none

module lifo_stack_with_search
   import lss_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [OP_W-1:0]          req_op,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [STATUS_W-1:0]           rsp_status,
   output logic signed [DATA_W-1:0]      rsp_data_out,
   output logic                          rsp_found,
   output logic [POS_W-1:0]              rsp_position,
   output logic [POS_W-1:0]              rsp_entry_count,
   output logic                          rsp_last
);

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type      state_ff, state_in;
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_ff, rsp_in;

   cell_ctrl_type         ctrl;
   logic                  can_load;
   logic                  rest_any;
   logic [WORD_WIDTH-1:0] key;
   logic [WORD_WIDTH-1:0] word_q [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] match_q;
   logic [STACK_DEPTH-1:0] occ;

   assign key = to_word(req_value);

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [WORD_WIDTH-1:0] above_w, below_w;
      logic                  below_m;

      if (i == 0) begin : g_top
         assign above_w = key;
      end else begin : g_mid
         assign above_w = word_q[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bot
         assign below_w = word_q[i];
         assign below_m = 1'b0;
      end else begin : g_up
         assign below_w = word_q[i+1];
         assign below_m = match_q[i+1];
      end

      assign occ[i] = (CNT_W'(i) < depth_ff);

      lss_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .occupied    (occ[i]),
         .key         (key),
         .above_word  (above_w),
         .below_word  (below_w),
         .below_match (below_m),
         .word_out    (word_q[i]),
         .match_out   (match_q[i])
      );
   end

   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign rest_any = |match_q[STACK_DEPTH-1:1];
   assign req_stall = !((state_ff == ST_IDLE) && can_load);

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      pos_in       = pos_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctrl         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               rsp_in             = '0;
               rsp_in.last        = 1'b1;
               rsp_in.entry_count = POS_W'(depth_ff);
               unique case (req_op)
                  OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (depth_ff == CNT_W'(STACK_DEPTH)) begin
                        rsp_in.status = STATUS_FULL;
                     end else begin
                        ctrl.push          = 1'b1;
                        depth_in           = depth_ff + 1'b1;
                        rsp_in.entry_count = POS_W'(depth_in);
                     end
                  end
                  OP_POP: begin
                     rsp_valid_in = 1'b1;
                     if (depth_ff == '0) begin
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        ctrl.pop           = 1'b1;
                        depth_in           = depth_ff - 1'b1;
                        rsp_in.entry_count = POS_W'(depth_in);
                        rsp_in.data_out    = from_word(word_q[0]);
                     end
                  end
                  OP_SEARCH: begin
                     if (depth_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_EMPTY;
                     end else begin
                        ctrl.load = 1'b1;
                        pos_in    = CNT_W'(1);
                        state_in  = ST_SCAN;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (!(|match_q)) begin
               // no match anywhere
               if (can_load) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in             = '0;
                  rsp_in.entry_count = POS_W'(depth_ff);
                  rsp_in.last        = 1'b1;
                  state_in           = ST_IDLE;
               end
            end else if (match_q[0]) begin
               if (can_load) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in             = '0;
                  rsp_in.found       = 1'b1;
                  rsp_in.position    = POS_W'(pos_ff);
                  rsp_in.entry_count = POS_W'(depth_ff);
                  rsp_in.last        = !rest_any;
                  ctrl.scan          = 1'b1;
                  pos_in             = pos_ff + 1'b1;
                  if (!rest_any) begin
                     state_in = ST_IDLE;
                  end
               end
            end else begin
               ctrl.scan = 1'b1;
               pos_in    = pos_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      pos_ff <= pos_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_data_out    = rsp_ff.data_out;
   assign rsp_found       = rsp_ff.found;
   assign rsp_position    = rsp_ff.position;
   assign rsp_entry_count = rsp_ff.entry_count;
   assign rsp_last        = rsp_ff.last;

endmodule

`default_nettype wire

FILE: bench/tb_lifo_stack_with_search.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_search
// Self-checking bench for the LIFO stack with search. A behavioural copy of
// the stack predicts every result beat; each accepted result is checked field
// by field in order. Directed cases cover the empty and full stack, the word
// extremes and multi-match search; random traffic and a long result hold-off
// follow, with bursty requests and stalled results.
// ----------------------------------------------------------------------------

module tb_lifo_stack_with_search
   import lss_pkg::*;
;

   localparam int CLK_HIGH       = 4;
   localparam int CLK_LOW        = 4;
   localparam int RESET_CYCLES   = 10;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = STACK_DEPTH + 8;

   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_op = OP_PUSH;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_data_out;
   logic                     rsp_found;
   logic [POS_W-1:0]         rsp_position;
   logic [POS_W-1:0]         rsp_entry_count;
   logic                     rsp_last;

   // stack model and the results it has predicted
   logic [WORD_WIDTH-1:0] stack_words [STACK_DEPTH];
   int                    stack_level = 0;
   rsp_type               pending_rsp_q [$];

   int             fail_count = 0;
   int             quiet_cycles = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_tick = 0;
   int             holdoff_asked = 0;
   int             holdoff_done = 0;

   lifo_stack_with_search i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_data_out    (rsp_data_out),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

   always begin
      #CLK_LOW clock = 1'b1;
      #CLK_HIGH clock = 1'b0;
   end

   function automatic void stack_predict(input logic [OP_W-1:0] op,
                                         input logic signed [DATA_W-1:0] value);
      logic [WORD_WIDTH-1:0] key;
      logic signed [63:0]    wide;
      rsp_type               r;
      int                    hits;
      int                    seen;
      wide = 64'(value);
      key  = wide[WORD_WIDTH-1:0];
      r    = '0;
      r.last = 1'b1;
      hits = 0;
      seen = 0;
      case (op)
         OP_PUSH: begin
            if (stack_level >= STACK_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               stack_words[stack_level] = key;
               stack_level++;
               r.status = STATUS_OK;
            end
            r.entry_count = POS_W'(stack_level);
            pending_rsp_q.push_back(r);
         end
         OP_POP: begin
            if (stack_level == 0) begin
               r.status = STATUS_EMPTY;
            end else begin
               stack_level--;
               wide = 64'(signed'(stack_words[stack_level]));
               r.status   = STATUS_OK;
               r.data_out = wide[DATA_W-1:0];
            end
            r.entry_count = POS_W'(stack_level);
            pending_rsp_q.push_back(r);
         end
         OP_SEARCH: begin
            r.entry_count = POS_W'(stack_level);
            if (stack_level == 0) begin
               r.status = STATUS_EMPTY;
               pending_rsp_q.push_back(r);
            end else begin
               for (int i = 0; i < stack_level; i++)
                  if (stack_words[stack_level-1-i] == key) hits++;
               r.status = STATUS_OK;
               if (hits == 0) begin
                  pending_rsp_q.push_back(r);
               end else begin
                  for (int i = 0; i < stack_level; i++) begin
                     if (stack_words[stack_level-1-i] == key) begin
                        seen++;
                        r.found    = 1'b1;
                        r.position = POS_W'(i + 1);
                        r.last     = (seen == hits);
                        pending_rsp_q.push_back(r);
                     end
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void compare_field(input string field, input longint want,
                                         input longint got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // result beats: sampled mid-cycle, taken at the next rising edge
   always @(negedge clock) begin : rsp_checker
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp_q.size() == 0) begin
            $error("result beat with none expected: status %0d, count %0d",
                   rsp_status, rsp_entry_count);
            fail_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            compare_field("status", want.status, rsp_status);
            compare_field("data_out", want.data_out, rsp_data_out);
            compare_field("found", want.found, rsp_found);
            compare_field("position", want.position, rsp_position);
            compare_field("entry_count", want.entry_count, rsp_entry_count);
            compare_field("last", want.last, rsp_last);
         end
      end
   end

   always @(negedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin : rsp_stall_gen
      forever begin
         @(posedge clock);
         if (holdoff_asked != holdoff_done) begin
            holdoff_done = holdoff_asked;
            rsp_stall <= 1'b1;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         stall_tick = (stall_tick + 1) % 7;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 6);
            default:     rsp_stall <= (stall_tick < 3);
         endcase
      end
   end

   task automatic send_beat(input logic [OP_W-1:0] op,
                            input logic signed [DATA_W-1:0] value);
      bit taken;
      taken = 1'b0;
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      while (!taken) begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end
      stack_predict(op, value);
   endtask

   function automatic logic signed [DATA_W-1:0] random_word();
      case ($urandom_range(0, 3))
         0, 1: return $urandom;
         2: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return -1;
               2:       return 32'sh7fffffff;
               default: return 32'sh80000000;
            endcase
         end
         default: return $urandom_range(0, 3);
      endcase
   endfunction

   task automatic run_traffic(input int items, input int push_pct, input int pop_pct,
                              input stall_mode_type mode, input bit bursts);
      int                       sent;
      int                       burst_left;
      int                       pick;
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
      stall_mode = mode;
      sent = 0;
      burst_left = $urandom_range(1, 8);
      while (sent < items) begin
         if (bursts && burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 8);
         end
         pick = $urandom_range(0, 99);
         if (pick < 3)
            op = OP_RESERVED;
         else if (pick < 3 + push_pct)
            op = OP_PUSH;
         else if (pick < 3 + push_pct + pop_pct)
            op = OP_POP;
         else
            op = OP_SEARCH;
         if (op == OP_SEARCH && stack_level > 0 && $urandom_range(0, 99) < 65)
            value = stack_words[$urandom_range(0, stack_level - 1)];
         else
            value = random_word();
         send_beat(op, value);
         if (op != OP_RESERVED) sent++;
         if (burst_left > 0) burst_left--;
      end
   endtask

   task automatic test_empty_stack();
      send_beat(OP_POP, '0);
      send_beat(OP_SEARCH, 32'sh80000000);
      send_beat(OP_RESERVED, -1);
   endtask

   // bottom, middle and top hold the same word so one search reports three hits
   task automatic test_fill_and_search();
      logic signed [DATA_W-1:0] fill [STACK_DEPTH];
      fill = '{32'sh80000000, 32'sh7fffffff, 32'sh0, -32'sd1, 32'sd1, 32'sh55555555,
               32'shaaaaaaaa, 32'sh80000000, 32'sd7, 32'sh12345678, -32'sd2,
               32'sh0000ffff, 32'shffff0000, 32'sh80000001, 32'sh7ffffffe,
               32'sh80000000};
      foreach (fill[i]) send_beat(OP_PUSH, fill[i]);
      send_beat(OP_PUSH, 32'sh7fffffff);
      send_beat(OP_RESERVED, 32'sh5a5a5a5a);
      send_beat(OP_SEARCH, 32'sh80000000);
      send_beat(OP_SEARCH, 32'sh7fffffff);
      send_beat(OP_SEARCH, 32'sd3);
      send_beat(OP_POP, -1);
   endtask

   task automatic test_random_traffic();
      run_traffic(35, 60, 15, STALL_NONE, 1'b0);
      run_traffic(35, 35, 35, STALL_LIGHT, 1'b1);
      run_traffic(30, 15, 60, STALL_HEAVY, 1'b1);
      run_traffic(25, 45, 30, STALL_PERIODIC, 1'b1);
   endtask

   // results held off for a long stretch while requests keep coming
   task automatic test_rsp_holdoff();
      holdoff_asked++;
      run_traffic(20, 40, 30, STALL_LIGHT, 1'b0);
   endtask

   initial begin : main
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_empty_stack();
      test_fill_and_search();
      test_random_traffic();
      test_rsp_holdoff();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
